### hw/rtl/epmd_pkg.sv
`default_nettype none

package epmd_pkg;

    // Field widths.
    localparam int STEP_W = 15;
    localparam int DUTY_W = 8;
    localparam int PCT_W  = 7;

    // Configuration port geometry.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register addresses.
    localparam logic [APB_AW-1:0] ADDR_TARGET_STEPS = 3'd0;

    // Item operation codes.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Counter limit.
    localparam logic [STEP_W-1:0] STEP_MAX = 15'h7FFF;

    // Drive law constants.
    localparam logic [PCT_W-1:0] BASE_PCT = 7'd30;
    localparam logic [PCT_W-1:0] MAX_PCT  = 7'd100;
    // Distance at which the percentage reaches its cap: (100 - 30) * 25.
    localparam logic [STEP_W-1:0] CAP_DIST = 15'd1750;

    // Reciprocals: x/25 as (x*5243)>>17 for x < 1750, and
    // x/100 as (x*5243)>>19 for x <= 25500. Both are exact over those ranges.
    localparam logic [12:0] RECIP_25  = 13'd5243;
    localparam int          SHIFT_25  = 17;
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          SHIFT_100 = 19;

endpackage

`default_nettype wire

### hw/rtl/epmd_if.sv
`default_nettype none

// Channel that carries one tick word.
interface epmd_tick_if;
    logic valid;
    logic ready;
    logic op;
    logic left_edge;
    logic right_edge;

    modport source (output valid, output op, output left_edge, output right_edge,
                    input ready);
    modport sink (input valid, input op, input left_edge, input right_edge,
                  output ready);
endinterface

// Channel that carries one result word.
interface epmd_result_if;
    logic                        valid;
    logic                        ready;
    logic [epmd_pkg::DUTY_W-1:0] left_duty;
    logic [epmd_pkg::DUTY_W-1:0] right_duty;
    logic                        move_done;
    logic [epmd_pkg::STEP_W-1:0] left_count;
    logic [epmd_pkg::STEP_W-1:0] right_count;

    modport source (output valid, output left_duty, output right_duty, output move_done,
                    output left_count, output right_count, input ready);
    modport sink (input valid, input left_duty, input right_duty, input move_done,
                  input left_count, input right_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/encoder_proportional_move_drive.sv
`default_nettype none

// Two-wheel proportional move controller. Each tick word carries one encoder edge
// flag per wheel (or a clear that zeroes both step counters); the block keeps a
// saturating 15-bit step count per wheel and returns one result word per tick with
// both counts, a duty of floor(255*p/100) per wheel where p = 30 + (target-steps)/25
// capped at 100 (0 once the wheel has overshot), and move_done with both duties
// forced to zero once both wheels have reached target_steps. The block takes one
// word every cycle unless a stalled result channel has filled all stages. A tick
// lands in the counter stage, then moves through the percentage stage (one
// constant multiply for the /25) and the duty stage (one constant multiply for the
// /100), each registered. A stalled result channel holds the words behind it in place.
// The user writes target_steps through the APB port at byte address 0 only while no
// word is in flight; the block does not enforce this. It reads back at the same address.
module encoder_proportional_move_drive
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    epmd_tick_if.sink                                tick,
    epmd_result_if.source                            result,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [epmd_pkg::APB_AW-1:0]         paddr,
    input  wire logic [epmd_pkg::APB_DW-1:0]         pwdata,
    output logic      [epmd_pkg::APB_DW-1:0]         prdata,
    output logic                                     pready
);

    localparam int SW = epmd_pkg::STEP_W;
    localparam int DW = epmd_pkg::DUTY_W;
    localparam int PW = epmd_pkg::PCT_W;

    // Percentage for one wheel; zero when the wheel has overshot.
    function automatic logic [PW-1:0] wheel_pct(input logic [SW-1:0] target,
                                                 input logic [SW-1:0] steps);
        logic [SW:0]   diff;
        logic [23:0]   prod;
        logic [PW-1:0] quo;
        logic [PW-1:0] pct;
        diff = {1'b0, target} - {1'b0, steps};
        prod = {13'd0, diff[10:0]} * {11'd0, epmd_pkg::RECIP_25};
        quo  = prod[epmd_pkg::SHIFT_25 +: PW];
        if (diff[SW])
        begin
            pct = '0;
        end
        else if (diff[SW-1:0] >= epmd_pkg::CAP_DIST)
        begin
            pct = epmd_pkg::MAX_PCT;
        end
        else
        begin
            pct = epmd_pkg::BASE_PCT + quo;
        end
        return pct;
    endfunction

    // Duty of floor(255*p/100).
    function automatic logic [DW-1:0] pct_duty(input logic [PW-1:0] pct);
        logic [14:0] scaled;
        logic [27:0] prod;
        scaled = {pct, 8'd0} - {8'd0, pct};
        prod   = {13'd0, scaled} * {15'd0, epmd_pkg::RECIP_100};
        return prod[epmd_pkg::SHIFT_100 +: DW];
    endfunction

    // Configuration register.
    logic [SW-1:0] target_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_wr && paddr == epmd_pkg::ADDR_TARGET_STEPS)
        begin
            target_reg <= pwdata[SW-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == epmd_pkg::ADDR_TARGET_STEPS)
        begin
            prdata = {{(epmd_pkg::APB_DW-SW){1'b0}}, target_reg};
        end
    end

    // Pipeline flow control.
    logic cnt_valid_reg;
    logic pct_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic pct_free;
    logic cnt_free;
    logic tick_acc;

    assign out_free   = !out_valid_reg || result.ready;
    assign pct_free   = !pct_valid_reg || out_free;
    assign cnt_free   = !cnt_valid_reg || pct_free;
    assign tick.ready = cnt_free;
    assign tick_acc   = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= 1'b0;
            pct_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cnt_free)
            begin
                cnt_valid_reg <= tick_acc;
            end
            if (pct_free)
            begin
                pct_valid_reg <= cnt_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= pct_valid_reg;
            end
        end
    end

    // Step counters; they hold the counts of the word in the counter stage.
    logic [SW-1:0] left_steps_reg;
    logic [SW-1:0] right_steps_reg;
    logic [SW-1:0] left_steps_next;
    logic [SW-1:0] right_steps_next;

    always_comb
    begin
        left_steps_next  = left_steps_reg;
        right_steps_next = right_steps_reg;
        if (tick.op == epmd_pkg::OP_CLEAR)
        begin
            left_steps_next  = '0;
            right_steps_next = '0;
        end
        else
        begin
            if (tick.left_edge && left_steps_reg != epmd_pkg::STEP_MAX)
            begin
                left_steps_next = left_steps_reg + 1'b1;
            end
            if (tick.right_edge && right_steps_reg != epmd_pkg::STEP_MAX)
            begin
                right_steps_next = right_steps_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_steps_reg  <= '0;
            right_steps_reg <= '0;
        end
        else if (tick_acc)
        begin
            left_steps_reg  <= left_steps_next;
            right_steps_reg <= right_steps_next;
        end
    end

    // Percentage stage.
    logic [PW-1:0] left_pct_reg;
    logic [PW-1:0] right_pct_reg;
    logic          done_pct_reg;
    logic [SW-1:0] left_cnt_pct_reg;
    logic [SW-1:0] right_cnt_pct_reg;
    logic          done_next;

    assign done_next = (left_steps_reg >= target_reg) && (right_steps_reg >= target_reg);

    always_ff @(posedge clk)
    begin
        if (pct_free && cnt_valid_reg)
        begin
            left_pct_reg      <= done_next ? '0 : wheel_pct(target_reg, left_steps_reg);
            right_pct_reg     <= done_next ? '0 : wheel_pct(target_reg, right_steps_reg);
            done_pct_reg      <= done_next;
            left_cnt_pct_reg  <= left_steps_reg;
            right_cnt_pct_reg <= right_steps_reg;
        end
    end

    // Result register.
    logic [DW-1:0] left_duty_reg;
    logic [DW-1:0] right_duty_reg;
    logic          done_out_reg;
    logic [SW-1:0] left_cnt_out_reg;
    logic [SW-1:0] right_cnt_out_reg;

    always_ff @(posedge clk)
    begin
        if (out_free && pct_valid_reg)
        begin
            left_duty_reg     <= pct_duty(left_pct_reg);
            right_duty_reg    <= pct_duty(right_pct_reg);
            done_out_reg      <= done_pct_reg;
            left_cnt_out_reg  <= left_cnt_pct_reg;
            right_cnt_out_reg <= right_cnt_pct_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.left_duty   = left_duty_reg;
    assign result.right_duty  = right_duty_reg;
    assign result.move_done   = done_out_reg;
    assign result.left_count  = left_cnt_out_reg;
    assign result.right_count = right_cnt_out_reg;

`ifndef ASSERT_OFF
    // A finished move always drives both motors off.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.move_done |-> result.left_duty == '0 && result.right_duty == '0)
    else $error("move_done with nonzero duty");

    // A clear word leaves both counters at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc && tick.op == epmd_pkg::OP_CLEAR |=> left_steps_reg == '0 && right_steps_reg == '0)
    else $error("counters not cleared");

    // Counters never move backward on a tick word.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_acc && tick.op == epmd_pkg::OP_TICK
        |=> left_steps_reg >= $past(left_steps_reg) && right_steps_reg >= $past(right_steps_reg))
    else $error("counter decreased on tick");

    // A word in the percentage stage is kept while the result register is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        pct_valid_reg && !out_free |=> pct_valid_reg && $stable(left_pct_reg))
    else $error("percentage stage lost a word");
`endif

endmodule

`default_nettype wire
